// File: sv/vgfpm_pkg.sv
// ----------------------------------------------------------------------------
// vgfpm_pkg
// Shared types and constants of the voice mixer: item kinds, register
// indexes, datapath operation codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package vgfpm_pkg;

  // item kinds
  localparam logic [2:0] KIND_FRAME    = 3'd0;
  localparam logic [2:0] KIND_FADE_OUT = 3'd1;
  localparam logic [2:0] KIND_FADE_IN  = 3'd2;
  localparam logic [2:0] KIND_CANCEL   = 3'd3;
  localparam logic [2:0] KIND_PAUSE    = 3'd4;
  localparam logic [2:0] KIND_UNPAUSE  = 3'd5;

  // configuration register indexes
  localparam int         CFG_IDX_W       = 2;
  localparam int         CFG_DATA_W      = 18;
  localparam logic [1:0] CFG_OUTPUT_RATE = 2'd0;
  localparam logic [1:0] CFG_VOICE_VOL   = 2'd1;
  localparam logic [1:0] CFG_PAN_POS     = 2'd2;

  // reset values of the registers
  localparam logic [17:0] RATE_RESET = 18'd48000;
  localparam logic [15:0] VOL_RESET  = 16'h8000;

  // Q1.15 fixed point
  localparam logic [15:0] UNITY    = 16'h8000;
  localparam int          HALF     = 16384;
  localparam int          MS_PER_S = 1000;

  // datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_SIMPLE, OP_PASS,
    OP_MUL_RATE, OP_LEN_DIV, OP_LEN_SAT, OP_RESC_MUL, OP_RESC_DIV, OP_FADE_SET,
    OP_VOL_MUL, OP_VOL_SQ, OP_RAMP_DIV, OP_F_FULL, OP_F_QUO, OP_F_MUL, OP_F_SQ,
    OP_GF_MUL, OP_G_SQ, OP_POS_STEP,
    OP_PA_MUL, OP_PA_SQ, OP_PB_MUL, OP_PB_SQ,
    OP_ROW_L, OP_ROW_R, OP_ROW_SUM, OP_ROW_DIV, OP_ROW_Q, OP_PG_MUL, OP_PG_OUT,
    OP_EMIT
  } dp_op_t;

  // command from controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   phase;  // 0 fade-out ramp, 1 fade-in ramp
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       paused;
    logic       out_nz;
    logic       in_nz;
    logic       ramp_full;
    logic       old_zero;
    logic       row;
    logic       div_busy;
    logic       out_busy;
  } dp_stat_t;

endpackage

// File: sv/vgfpm_if.sv
// ----------------------------------------------------------------------------
// vgfpm_if
// Valid/ready channels of the voice mixer: input items and bus results.
// ----------------------------------------------------------------------------
interface vgfpm_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int BUS_BITS    = 24
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    kind;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic signed [BUS_BITS-1:0]    bus_in_left;
  logic signed [BUS_BITS-1:0]    bus_in_right;
  logic [15:0]                   fade_ms;

  modport source (output valid, kind, sample_left, sample_right, bus_in_left,
                  bus_in_right, fade_ms, input ready);
  modport sink (input valid, kind, sample_left, sample_right, bus_in_left,
                bus_in_right, fade_ms, output ready);
endinterface

interface vgfpm_out_if #(
  parameter int BUS_BITS = 24
);
  logic                       valid;
  logic                       ready;
  logic signed [BUS_BITS-1:0] bus_out_left;
  logic signed [BUS_BITS-1:0] bus_out_right;

  modport source (output valid, bus_out_left, bus_out_right, input ready);
  modport sink (input valid, bus_out_left, bus_out_right, output ready);
endinterface

// File: sv/voice_gain_fade_pan_mixer_core.sv
// ----------------------------------------------------------------------------
// voice_gain_fade_pan_mixer_core
// One mixer voice: squared volume, fade ramps, squared pan law and
// saturating add onto the stereo mix bus.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  in_ch     sink       kind, samples, bus values, fade_ms
//  out_ch    source     bus_out_left, bus_out_right (frames only)
//  cfg_*     write      output_rate, voice_volume, pan_position
//
// Items are handled one at a time; in_ch.ready is high only between items.
// Divide steps take a DW-bit dividend, DW = 2*max(FADE_COUNTER_BITS,
// SAMPLE_BITS, 18) (48 at defaults). A paused frame skips the arithmetic;
// an active frame divides once per output row and once per running fade
// ramp short of full, a fade command once when the opposite fade runs.
// Reset leaves the voice paused with no fade; a stalled result holds the
// next frame in its last step until out_ch takes the pending transaction.
module voice_gain_fade_pan_mixer_core import vgfpm_pkg::*; #(
  parameter int SAMPLE_BITS       = 16,
  parameter int BUS_BITS          = 24,
  parameter int FADE_COUNTER_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vgfpm_in_if.sink              in_ch,
  vgfpm_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // step sequencer
  vgfpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and state
  vgfpm_dp #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .BUS_BITS          (BUS_BITS),
    .FADE_COUNTER_BITS (FADE_COUNTER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_ch.kind),
    .in_sample_left    (in_ch.sample_left),
    .in_sample_right   (in_ch.sample_right),
    .in_bus_in_left    (in_ch.bus_in_left),
    .in_bus_in_right   (in_ch.bus_in_right),
    .in_fade_ms        (in_ch.fade_ms),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_bus_out_left  (out_ch.bus_out_left),
    .out_bus_out_right (out_ch.bus_out_right)
  );

endmodule

// File: sv/vgfpm_div.sv
// ----------------------------------------------------------------------------
// vgfpm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgfpm_div #(
  parameter int DW = 48,
  parameter int VW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] den_r;
  logic [VW:0]   shifted;
  logic [VW+1:0] trial;

  // trial subtraction of the divisor from the shifted remainder
  assign shifted = {rem_r, quo_r[DW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      if (trial[VW+1]) begin
        rem_r <= shifted[VW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end else begin
        rem_r <= trial[VW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// File: sv/vgfpm_dp.sv
// ----------------------------------------------------------------------------
// vgfpm_dp
// Mixer datapath: registers, voice state, shared multiplier and divider,
// pan and saturation logic and the result register.
// ----------------------------------------------------------------------------
module vgfpm_dp import vgfpm_pkg::*; #(
  parameter int SAMPLE_BITS       = 16,
  parameter int BUS_BITS          = 24,
  parameter int FADE_COUNTER_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  input  logic [2:0]                    in_kind,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_right,
  input  logic signed [BUS_BITS-1:0]    in_bus_in_left,
  input  logic signed [BUS_BITS-1:0]    in_bus_in_right,
  input  logic [15:0]                   in_fade_ms,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [BUS_BITS-1:0]    out_bus_out_left,
  output logic signed [BUS_BITS-1:0]    out_bus_out_right
);

  localparam int SB  = SAMPLE_BITS;
  localparam int BB  = BUS_BITS;
  localparam int FCB = FADE_COUNTER_BITS;
  localparam int M1  = (FCB > SB) ? FCB : SB;
  localparam int MW  = (M1 > 18) ? M1 : 18;
  localparam int DW  = 2 * MW;
  localparam int SW  = ((BB > SB) ? BB : SB) + 2;
  localparam longint BHI = (longint'(1) << (BB - 1)) - 1;
  localparam longint BLO = -BHI - 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(BHI);
  localparam logic signed [SW-1:0] SAT_LO = SW'(BLO);
  // ceil(2^38 / 125), exact floor division by 125 for operands below 2^31
  localparam logic [31:0] LEN_RECIP = 32'd2199023256;
  localparam logic [63:0] CNT_MAX64 = (64'd1 << FCB) - 64'd1;

  // configuration
  logic [17:0]        rate_r;
  logic [15:0]        vol_r;
  logic signed [15:0] pan_r;

  // voice state
  logic           paused_r;
  logic [FCB-1:0] out_len_r;
  logic [FCB-1:0] in_len_r;
  logic [FCB-1:0] pos_r;

  // captured item
  logic [2:0]           kind_r;
  logic [SB-1:0]        l_mag_r;
  logic                 l_neg_r;
  logic [SB-1:0]        r_mag_r;
  logic                 r_neg_r;
  logic signed [BB-1:0] bl_r;
  logic signed [BB-1:0] br_r;
  logic [15:0]          ms_r;

  // working registers
  logic [DW-1:0]          prod_r;
  logic [15:0]            g_r;
  logic [15:0]            f_r;
  logic [15:0]            a_sq_r;
  logic [15:0]            b_sq_r;
  logic [FCB-1:0]         n_r;
  logic [47:0]            len_lo_r;
  logic signed [DW+1:0]   acc_r;
  logic [SB-1:0]          pan_mag_r;
  logic                   pan_neg_r;
  logic                   row_r;
  logic signed [BB-1:0]   res_l_r;
  logic signed [BB-1:0]   res_r_r;
  logic signed [BB-1:0]   out_l_r;
  logic signed [BB-1:0]   out_r_r;
  logic                   out_valid_r;

  logic [15:0]          vol_c;
  logic [15:0]          a_c;
  logic [15:0]          b_c;
  logic [15:0]          gl_c;
  logic [15:0]          gr_c;
  logic [16:0]          t_c;
  logic [16:0]          den_c;
  logic [FCB-1:0]       old_c;
  logic [FCB-1:0]       d_old_c;
  logic [FCB-1:0]       din_c;
  logic [FCB-1:0]       ramp_len_c;
  logic [FCB-1:0]       ramp_part_c;
  logic [FCB-1:0]       pos_dec_c;
  logic [30:0]          len_y_c;
  logic [47:0]          len_lo_c;
  logic [46:0]          len_hi_c;
  logic [63:0]          len_sum_c;
  logic [25:0]          len_q_c;
  logic [MW-1:0]        mul_a;
  logic [MW-1:0]        mul_b;
  logic [DW-1:0]        mul_p;
  logic [DW-1:0]        rnd_c;
  logic signed [DW+1:0] prod_s;
  logic [DW+1:0]        acc_mag;
  logic                 div_start;
  logic [DW-1:0]        div_num;
  logic [MW-1:0]        div_den;
  logic                 div_busy;
  logic [DW-1:0]        quo;
  logic [SB-1:0]        l_in_mag;
  logic [SB-1:0]        r_in_mag;
  logic signed [SW-1:0] c_ext;
  logic signed [SW-1:0] c_s;
  logic signed [SW-1:0] sum_s;
  logic signed [BB-1:0] sat_c;

  // volume clamp and pan coefficients
  assign vol_c = (vol_r > UNITY) ? UNITY : vol_r;
  assign a_c   = pan_r[15] ? UNITY : UNITY - $unsigned(pan_r);
  assign b_c   = pan_r[15] ? UNITY + $unsigned(pan_r) : UNITY;
  assign gl_c  = row_r ? UNITY - a_sq_r : a_sq_r;
  assign gr_c  = row_r ? b_sq_r : UNITY - b_sq_r;
  assign t_c   = {1'b0, gl_c} + {1'b0, gr_c};
  assign den_c = (t_c > {1'b0, UNITY}) ? t_c : {1'b0, UNITY};

  // fade counter arithmetic
  assign old_c       = (kind_r == KIND_FADE_OUT) ? in_len_r : out_len_r;
  assign d_old_c     = (old_c > pos_r) ? old_c - pos_r : '0;
  assign din_c       = (in_len_r > pos_r) ? in_len_r - pos_r : '0;
  assign ramp_len_c  = cmd.phase ? in_len_r : out_len_r;
  assign ramp_part_c = cmd.phase ? din_c : pos_r;
  assign pos_dec_c   = (pos_r == '0) ? '0 : pos_r - 1'b1;

  // fade length in frames: floor(rate*ms/1000) = floor((rate*ms >> 3) / 125),
  // by reciprocal multiply split into a low and a high half over two steps
  assign len_y_c   = prod_r[33:3];
  assign len_lo_c  = {32'b0, len_y_c[15:0]} * {16'b0, LEN_RECIP};
  assign len_hi_c  = {32'b0, len_y_c[30:16]} * {15'b0, LEN_RECIP};
  assign len_sum_c = {1'b0, len_hi_c, 16'b0} + {16'b0, len_lo_r};
  assign len_q_c   = len_sum_c[63:38];

  // sample magnitudes
  assign l_in_mag = in_sample_left[SB-1] ? $unsigned(-in_sample_left)
                                         : $unsigned(in_sample_left);
  assign r_in_mag = in_sample_right[SB-1] ? $unsigned(-in_sample_right)
                                          : $unsigned(in_sample_right);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_RATE: begin mul_a = MW'(rate_r);    mul_b = MW'(ms_r);   end
      OP_RESC_MUL: begin mul_a = MW'(d_old_c);   mul_b = MW'(n_r);    end
      OP_VOL_MUL:  begin mul_a = MW'(vol_c);     mul_b = MW'(vol_c);  end
      OP_F_MUL:    begin mul_a = MW'(f_r);       mul_b = MW'(f_r);    end
      OP_GF_MUL:   begin mul_a = MW'(g_r);       mul_b = MW'(f_r);    end
      OP_PA_MUL:   begin mul_a = MW'(a_c);       mul_b = MW'(a_c);    end
      OP_PB_MUL:   begin mul_a = MW'(b_c);       mul_b = MW'(b_c);    end
      OP_ROW_L:    begin mul_a = MW'(l_mag_r);   mul_b = MW'(gl_c);   end
      OP_ROW_R:    begin mul_a = MW'(r_mag_r);   mul_b = MW'(gr_c);   end
      OP_PG_MUL:   begin mul_a = MW'(pan_mag_r); mul_b = MW'(g_r);    end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign rnd_c   = (prod_r + DW'(HALF)) >> 15;
  assign prod_s  = $signed({2'b00, prod_r});
  assign acc_mag = acc_r[DW+1] ? $unsigned(-acc_r) : $unsigned(acc_r);

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    div_num   = prod_r;
    div_den   = MW'(old_c);
    case (cmd.op)
      OP_RESC_DIV: begin
        div_num = prod_r;
        div_den = MW'(old_c);
      end
      OP_RAMP_DIV: begin
        div_num = DW'(ramp_part_c) << 15;
        div_den = MW'(ramp_len_c);
      end
      OP_ROW_DIV: begin
        div_num = DW'(acc_mag + (DW+2)'(den_c >> 1));
        div_den = MW'(den_c);
      end
      default: div_start = 1'b0;
    endcase
  end

  vgfpm_div #(.DW(DW), .VW(MW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (quo)
  );

  // contribution of one row and bus saturation
  assign c_ext = $signed({{(SW-SB){1'b0}}, rnd_c[SB-1:0]});
  assign c_s   = pan_neg_r ? -c_ext : c_ext;
  assign sum_s = (row_r ? SW'(br_r) : SW'(bl_r)) + c_s;
  assign sat_c = (sum_s > SAT_HI) ? SAT_HI[BB-1:0] :
                 (sum_s < SAT_LO) ? SAT_LO[BB-1:0] : sum_s[BB-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
      vol_r  <= VOL_RESET;
      pan_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUTPUT_RATE: rate_r <= cfg_wdata[17:0];
        CFG_VOICE_VOL:   vol_r  <= cfg_wdata[15:0];
        CFG_PAN_POS:     pan_r  <= $signed(cfg_wdata[15:0]);
        default: ;
      endcase
    end
  end

  // voice state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r    <= 1'b1;
      out_len_r   <= '0;
      in_len_r    <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_SIMPLE: begin
          case (kind_r)
            KIND_CANCEL: begin
              out_len_r <= '0;
              in_len_r  <= '0;
            end
            KIND_PAUSE:   paused_r <= 1'b1;
            KIND_UNPAUSE: paused_r <= 1'b0;
            default: ;
          endcase
        end
        OP_FADE_SET: begin
          pos_r <= (old_c == '0) ? n_r : quo[FCB-1:0];
          if (kind_r == KIND_FADE_OUT) begin
            out_len_r <= n_r;
            in_len_r  <= '0;
          end else begin
            in_len_r  <= n_r;
            out_len_r <= '0;
          end
        end
        OP_POS_STEP: begin
          pos_r <= pos_dec_c;
          if (cmd.phase && pos_dec_c == '0) begin
            in_len_r <= '0;
          end
        end
        OP_EMIT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL_RATE, OP_RESC_MUL, OP_VOL_MUL, OP_F_MUL, OP_GF_MUL, OP_PA_MUL,
      OP_PB_MUL, OP_ROW_L, OP_PG_MUL: prod_r <= mul_p;
      OP_ROW_R: begin
        prod_r <= mul_p;
        acc_r  <= l_neg_r ? -prod_s : prod_s;
      end
      default: ;
    endcase
    case (cmd.op)
      OP_CAPTURE: begin
        kind_r  <= in_kind;
        l_mag_r <= l_in_mag;
        l_neg_r <= in_sample_left[SB-1];
        r_mag_r <= r_in_mag;
        r_neg_r <= in_sample_right[SB-1];
        bl_r    <= in_bus_in_left;
        br_r    <= in_bus_in_right;
        ms_r    <= in_fade_ms;
        row_r   <= 1'b0;
      end
      OP_LEN_DIV: len_lo_r <= len_lo_c;
      OP_LEN_SAT: n_r <= ({38'b0, len_q_c} > CNT_MAX64) ? '1 : FCB'(len_q_c);
      OP_PASS: begin
        res_l_r <= bl_r;
        res_r_r <= br_r;
      end
      OP_VOL_SQ:  g_r    <= rnd_c[15:0];
      OP_F_FULL:  f_r    <= UNITY;
      OP_F_QUO:   f_r    <= quo[15:0];
      OP_F_SQ:    f_r    <= rnd_c[15:0];
      OP_G_SQ:    g_r    <= rnd_c[15:0];
      OP_PA_SQ:   a_sq_r <= rnd_c[15:0];
      OP_PB_SQ:   b_sq_r <= rnd_c[15:0];
      OP_ROW_SUM: acc_r  <= acc_r + (r_neg_r ? -prod_s : prod_s);
      OP_ROW_Q: begin
        pan_mag_r <= quo[SB-1:0];
        pan_neg_r <= acc_r[DW+1];
      end
      OP_PG_OUT: begin
        if (row_r) begin
          res_r_r <= sat_c;
        end else begin
          res_l_r <= sat_c;
        end
        row_r <= ~row_r;
      end
      // result payload, held while the transaction waits on out_ready
      OP_EMIT: begin
        out_l_r <= res_l_r;
        out_r_r <= res_r_r;
      end
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat.kind      = kind_r;
    stat.paused    = paused_r;
    stat.out_nz    = (out_len_r != '0);
    stat.in_nz     = (in_len_r != '0);
    stat.ramp_full = (ramp_part_c >= ramp_len_c);
    stat.old_zero  = (old_c == '0);
    stat.row       = row_r;
    stat.div_busy  = div_busy;
    stat.out_busy  = out_valid_r;
  end

  assign out_valid         = out_valid_r;
  assign out_bus_out_left  = out_l_r;
  assign out_bus_out_right = out_r_r;

endmodule

// File: sv/vgfpm_ctrl.sv
// ----------------------------------------------------------------------------
// vgfpm_ctrl
// Sequencer of the voice mixer: walks each item through the datapath steps.
// ----------------------------------------------------------------------------
module vgfpm_ctrl import vgfpm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_DECODE, ST_SIMPLE, ST_PASS,
    ST_LEN_MUL, ST_LEN_DIV, ST_LEN_WAIT, ST_LEN_SAT,
    ST_RESC_MUL, ST_RESC_DIV, ST_RESC_WAIT, ST_FADE_SET,
    ST_VOL_MUL, ST_VOL_SQ, ST_FADE_SEL, ST_RAMP_CHK, ST_RAMP_WAIT, ST_RAMP_QUO,
    ST_F_MUL, ST_F_SQ, ST_GF_MUL, ST_G_SQ, ST_POS_STEP,
    ST_PA_MUL, ST_PA_SQ, ST_PB_MUL, ST_PB_SQ,
    ST_ROW_L, ST_ROW_R, ST_ROW_SUM, ST_ROW_DIV, ST_ROW_WAIT, ST_ROW_Q,
    ST_PG_MUL, ST_PG_OUT, ST_EMIT
  } state_t;

  state_t state_r;
  logic   phase_r;

  // step sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE:   if (in_valid) state_r <= ST_DECODE;
        ST_DECODE: begin
          case (stat.kind)
            KIND_FRAME:    state_r <= stat.paused ? ST_PASS : ST_VOL_MUL;
            KIND_FADE_OUT, KIND_FADE_IN: state_r <= ST_LEN_MUL;
            KIND_CANCEL, KIND_PAUSE, KIND_UNPAUSE: state_r <= ST_SIMPLE;
            default:       state_r <= ST_IDLE;
          endcase
        end
        ST_SIMPLE:    state_r <= ST_IDLE;
        ST_PASS:      state_r <= ST_EMIT;
        // fade command: length in frames, then counter rescale
        ST_LEN_MUL:   state_r <= ST_LEN_DIV;
        ST_LEN_DIV:   state_r <= ST_LEN_WAIT;
        ST_LEN_WAIT:  if (!stat.div_busy) state_r <= ST_LEN_SAT;
        ST_LEN_SAT:   state_r <= stat.old_zero ? ST_FADE_SET : ST_RESC_MUL;
        ST_RESC_MUL:  state_r <= ST_RESC_DIV;
        ST_RESC_DIV:  state_r <= ST_RESC_WAIT;
        ST_RESC_WAIT: if (!stat.div_busy) state_r <= ST_FADE_SET;
        ST_FADE_SET:  state_r <= ST_IDLE;
        // frame: squared volume, then fade ramps
        ST_VOL_MUL:   state_r <= ST_VOL_SQ;
        ST_VOL_SQ:    state_r <= ST_FADE_SEL;
        ST_FADE_SEL: begin
          if (stat.out_nz) begin
            phase_r <= 1'b0;
            state_r <= ST_RAMP_CHK;
          end else if (stat.in_nz) begin
            phase_r <= 1'b1;
            state_r <= ST_RAMP_CHK;
          end else begin
            state_r <= ST_PA_MUL;
          end
        end
        ST_RAMP_CHK:  state_r <= stat.ramp_full ? ST_F_MUL : ST_RAMP_WAIT;
        ST_RAMP_WAIT: if (!stat.div_busy) state_r <= ST_RAMP_QUO;
        ST_RAMP_QUO:  state_r <= ST_F_MUL;
        ST_F_MUL:     state_r <= ST_F_SQ;
        ST_F_SQ:      state_r <= ST_GF_MUL;
        ST_GF_MUL:    state_r <= ST_G_SQ;
        ST_G_SQ:      state_r <= ST_POS_STEP;
        ST_POS_STEP: begin
          if (!phase_r && stat.in_nz) begin
            phase_r <= 1'b1;
            state_r <= ST_RAMP_CHK;
          end else begin
            state_r <= ST_PA_MUL;
          end
        end
        // pan law
        ST_PA_MUL:    state_r <= ST_PA_SQ;
        ST_PA_SQ:     state_r <= ST_PB_MUL;
        ST_PB_MUL:    state_r <= ST_PB_SQ;
        ST_PB_SQ:     state_r <= ST_ROW_L;
        // one output row per pass
        ST_ROW_L:     state_r <= ST_ROW_R;
        ST_ROW_R:     state_r <= ST_ROW_SUM;
        ST_ROW_SUM:   state_r <= ST_ROW_DIV;
        ST_ROW_DIV:   state_r <= ST_ROW_WAIT;
        ST_ROW_WAIT:  if (!stat.div_busy) state_r <= ST_ROW_Q;
        ST_ROW_Q:     state_r <= ST_PG_MUL;
        ST_PG_MUL:    state_r <= ST_PG_OUT;
        ST_PG_OUT:    state_r <= stat.row ? ST_EMIT : ST_ROW_L;
        ST_EMIT:      if (!stat.out_busy) state_r <= ST_IDLE;
        default:      state_r <= ST_IDLE;
      endcase
    end
  end

  // step decode into datapath command
  always_comb begin
    cmd.phase = phase_r;
    case (state_r)
      ST_IDLE:      cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
      ST_SIMPLE:    cmd.op = OP_SIMPLE;
      ST_PASS:      cmd.op = OP_PASS;
      ST_LEN_MUL:   cmd.op = OP_MUL_RATE;
      ST_LEN_DIV:   cmd.op = OP_LEN_DIV;
      ST_LEN_SAT:   cmd.op = OP_LEN_SAT;
      ST_RESC_MUL:  cmd.op = OP_RESC_MUL;
      ST_RESC_DIV:  cmd.op = OP_RESC_DIV;
      ST_FADE_SET:  cmd.op = OP_FADE_SET;
      ST_VOL_MUL:   cmd.op = OP_VOL_MUL;
      ST_VOL_SQ:    cmd.op = OP_VOL_SQ;
      ST_RAMP_CHK:  cmd.op = stat.ramp_full ? OP_F_FULL : OP_RAMP_DIV;
      ST_RAMP_QUO:  cmd.op = OP_F_QUO;
      ST_F_MUL:     cmd.op = OP_F_MUL;
      ST_F_SQ:      cmd.op = OP_F_SQ;
      ST_GF_MUL:    cmd.op = OP_GF_MUL;
      ST_G_SQ:      cmd.op = OP_G_SQ;
      ST_POS_STEP:  cmd.op = OP_POS_STEP;
      ST_PA_MUL:    cmd.op = OP_PA_MUL;
      ST_PA_SQ:     cmd.op = OP_PA_SQ;
      ST_PB_MUL:    cmd.op = OP_PB_MUL;
      ST_PB_SQ:     cmd.op = OP_PB_SQ;
      ST_ROW_L:     cmd.op = OP_ROW_L;
      ST_ROW_R:     cmd.op = OP_ROW_R;
      ST_ROW_SUM:   cmd.op = OP_ROW_SUM;
      ST_ROW_DIV:   cmd.op = OP_ROW_DIV;
      ST_ROW_Q:     cmd.op = OP_ROW_Q;
      ST_PG_MUL:    cmd.op = OP_PG_MUL;
      ST_PG_OUT:    cmd.op = OP_PG_OUT;
      ST_EMIT:      cmd.op = stat.out_busy ? OP_NONE : OP_EMIT;
      default:      cmd.op = OP_NONE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for one mixer voice: directed table of frames and
// commands, then random traffic checked against an in-bench gain/fade/pan
// predictor, under several idling phases and register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import vgfpm_pkg::*;

  localparam int SB = 16;
  localparam int BB = 24;
  localparam int CB = 24;
  localparam longint CNT_MAX = (64'd1 << CB) - 1;
  localparam longint BUS_HI = (64'd1 << (BB - 1)) - 1;
  localparam longint BUS_LO = -BUS_HI - 1;
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic [2:0] kind;
    logic signed [SB-1:0] sl;
    logic signed [SB-1:0] sr;
    logic signed [BB-1:0] bl;
    logic signed [BB-1:0] br;
    logic [15:0] ms;
    bit known;
    logic signed [BB-1:0] el;
    logic signed [BB-1:0] er;
  } row_t;

  typedef struct {
    logic signed [BB-1:0] l;
    logic signed [BB-1:0] r;
  } bus_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  vgfpm_in_if #(.SAMPLE_BITS(SB), .BUS_BITS(BB)) in_ch ();
  vgfpm_out_if #(.BUS_BITS(BB)) out_ch ();

  voice_gain_fade_pan_mixer_core #(
    .SAMPLE_BITS(SB), .BUS_BITS(BB), .FADE_COUNTER_BITS(CB)
  ) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  longint m_rate, m_vol, m_pan;
  bit m_paused;
  longint m_out_len, m_in_len, m_pos;

  bus_pair_t mix_expected[$];
  int errors = 0;
  int src_idle = 0;
  int snk_stall = 0;
  longint cycles = 0;

  function automatic longint sq(longint x);
    return (x * x + 16384) >>> 15;
  endfunction

  function automatic longint rdiv(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint ramp(longint part, longint len);
    if (part >= len) return 32768;
    return (part << 15) / len;
  endfunction

  function automatic longint fade_frames(longint ms);
    longint n;
    n = (m_rate * ms) / MS_PER_S;
    return n > CNT_MAX ? CNT_MAX : n;
  endfunction

  function automatic longint rescale_pos(longint old_len, longint new_len);
    longint d;
    if (old_len == 0) return new_len;
    d = old_len > m_pos ? old_len - m_pos : 0;
    return (d * new_len) / old_len;
  endfunction

  function automatic logic signed [BB-1:0] sat_add(longint bus, longint add);
    longint s;
    s = bus + add;
    if (s > BUS_HI) s = BUS_HI;
    if (s < BUS_LO) s = BUS_LO;
    return s[BB-1:0];
  endfunction

  // advance voice state by one item; returns 1 with the bus pair for frames
  function automatic bit mix_voice(row_t it, output bus_pair_t res);
    longint n, g, f, d, a, b, ga, gb, gl, gr, num, t, panned, p;
    res.l = '0;
    res.r = '0;
    case (it.kind)
      KIND_FADE_OUT: begin
        n = fade_frames(it.ms);
        m_pos = rescale_pos(m_in_len, n);
        m_out_len = n;
        m_in_len = 0;
        return 0;
      end
      KIND_FADE_IN: begin
        n = fade_frames(it.ms);
        m_pos = rescale_pos(m_out_len, n);
        m_in_len = n;
        m_out_len = 0;
        return 0;
      end
      KIND_CANCEL: begin
        m_out_len = 0;
        m_in_len = 0;
        return 0;
      end
      KIND_PAUSE: begin
        m_paused = 1;
        return 0;
      end
      KIND_UNPAUSE: begin
        m_paused = 0;
        return 0;
      end
      KIND_FRAME: ;
      default: return 0;
    endcase
    if (m_paused) begin
      res.l = it.bl;
      res.r = it.br;
      return 1;
    end
    g = sq(m_vol > 32768 ? 32768 : m_vol);
    if (m_out_len != 0) begin
      f = sq(ramp(m_pos, m_out_len));
      g = rdiv(g * f, 32768);
      if (m_pos != 0) m_pos--;
    end
    if (m_in_len != 0) begin
      d = m_in_len > m_pos ? m_in_len - m_pos : 0;
      f = sq(ramp(d, m_in_len));
      g = rdiv(g * f, 32768);
      if (m_pos != 0) m_pos--;
      if (m_pos == 0) m_in_len = 0;
    end
    p = m_pan;
    a = 32768 - (p > 0 ? p : 0);
    b = 32768 - (p < 0 ? -p : 0);
    ga = sq(a);
    gb = sq(b);
    for (int j = 0; j < 2; j++) begin
      gl = j == 0 ? ga : 32768 - ga;
      gr = j == 0 ? 32768 - gb : gb;
      num = longint'(it.sl) * gl + longint'(it.sr) * gr;
      t = gl + gr;
      panned = rdiv(num, t > 32768 ? t : 32768);
      panned = rdiv(panned * g, 32768);
      if (j == 0) res.l = sat_add(it.bl, panned);
      else res.r = sat_add(it.br, panned);
    end
    return 1;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall and compare against oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (mix_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %0d %0d",
                                     out_ch.bus_out_left, out_ch.bus_out_right);
        end else begin
          bus_pair_t e;
          e = mix_expected.pop_front();
          if (e.l !== out_ch.bus_out_left || e.r !== out_ch.bus_out_right) begin
            errors++;
            if (errors <= 10)
              $display("bus mismatch: expected %0d/%0d got %0d/%0d",
                       e.l, e.r, out_ch.bus_out_left, out_ch.bus_out_right);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OUTPUT_RATE: m_rate = val & 64'h3FFFF;
      CFG_VOICE_VOL: m_vol = val & 64'hFFFF;
      CFG_PAN_POS: m_pan = longint'($signed(16'(val)));
      default: ;
    endcase
  endtask

  // drive one transaction; valid stays high when the next follows at once
  task automatic send_item(row_t it);
    bus_pair_t res;
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.sample_left <= it.sl;
    in_ch.sample_right <= it.sr;
    in_ch.bus_in_left <= it.bl;
    in_ch.bus_in_right <= it.br;
    in_ch.fade_ms <= it.ms;
    do @(posedge clk); while (!in_ch.ready);
    if (mix_voice(it, res)) begin
      if (it.known && (res.l !== it.el || res.r !== it.er)) begin
        errors++;
        if (errors <= 10)
          $display("table row mismatch: expected %0d/%0d predicted %0d/%0d",
                   it.el, it.er, res.l, res.r);
      end
      mix_expected.push_back(res);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic row_t mk(logic [2:0] k, int sl, int sr, int bl, int br, int ms);
    row_t r;
    r.kind = k;
    r.sl = SB'(sl);
    r.sr = SB'(sr);
    r.bl = BB'(bl);
    r.br = BB'(br);
    r.ms = 16'(ms);
    r.known = 0;
    r.el = '0;
    r.er = '0;
    return r;
  endfunction

  function automatic row_t rand_item();
    row_t r;
    int sel;
    sel = $urandom_range(99);
    r = mk(KIND_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (sel < 15) r.bl = BB'($urandom_range(1) ? BUS_HI - $urandom_range(50000)
                                               : BUS_LO + $urandom_range(50000));
    if (sel >= 80) begin
      r.kind = 3'($urandom_range(7));
      // mostly short fades so ramps actually play out
      if ($urandom_range(3) != 0) r.ms = 16'($urandom_range(3));
    end
    return r;
  endfunction

  initial begin
    row_t dir[$];
    row_t t;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_FRAME;
    in_ch.sample_left = '0;
    in_ch.sample_right = '0;
    in_ch.bus_in_left = '0;
    in_ch.bus_in_right = '0;
    in_ch.fade_ms = '0;
    m_rate = 48000;
    m_vol = 32768;
    m_pan = 0;
    m_paused = 1;
    m_out_len = 0;
    m_in_len = 0;
    m_pos = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: paused passthrough, extremes, every kind
    t = mk(KIND_FRAME, 32767, -32768, 8388607, -8388608, 0);
    t.known = 1; t.el = 8388607; t.er = -8388608;
    dir.push_back(t);
    dir.push_back(mk(3'd6, 1, 1, 1, 1, 1));
    dir.push_back(mk(3'd7, 1, 1, 1, 1, 1));
    dir.push_back(mk(KIND_UNPAUSE, 0, 0, 0, 0, 0));
    t = mk(KIND_FRAME, 0, 0, 123, -456, 0);
    t.known = 1; t.el = 123; t.er = -456;
    dir.push_back(t);
    dir.push_back(mk(KIND_FRAME, 32767, 32767, 8388607, 8388607, 0));
    dir.push_back(mk(KIND_FRAME, -32768, -32768, -8388608, -8388608, 0));
    dir.push_back(mk(KIND_FADE_OUT, 0, 0, 0, 0, 0));
    dir.push_back(mk(KIND_FRAME, 1000, -1000, 0, 0, 0));
    dir.push_back(mk(KIND_FADE_OUT, 0, 0, 0, 0, 1));
    for (int i = 0; i < 4; i++) dir.push_back(mk(KIND_FRAME, 20000, -20000, 0, 0, 0));
    dir.push_back(mk(KIND_FADE_IN, 0, 0, 0, 0, 1));
    for (int i = 0; i < 3; i++) dir.push_back(mk(KIND_FRAME, -30000, 30000, 7, 7, 0));
    dir.push_back(mk(KIND_FADE_OUT, 0, 0, 0, 0, 65535));
    dir.push_back(mk(KIND_FRAME, 5, 5, 0, 0, 0));
    dir.push_back(mk(KIND_FADE_IN, 0, 0, 0, 0, 65535));
    dir.push_back(mk(KIND_CANCEL, 0, 0, 0, 0, 0));
    dir.push_back(mk(KIND_PAUSE, 0, 0, 0, 0, 0));
    t = mk(KIND_FRAME, 9, 9, -77, 77, 0);
    t.known = 1; t.el = -77; t.er = 77;
    dir.push_back(t);
    dir.push_back(mk(KIND_UNPAUSE, 0, 0, 0, 0, 0));
    foreach (dir[i]) send_item(dir[i]);
    drain();

    // random phases over register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle = 0; snk_stall = 0; end
        1: begin src_idle = 63; snk_stall = 0; end
        2: begin src_idle = 0; snk_stall = 63; end
        default: begin src_idle = 12; snk_stall = 12; end
      endcase
      case (ph)
        0: begin write_reg(CFG_OUTPUT_RATE, 8000); write_reg(CFG_VOICE_VOL, 0);
                 write_reg(CFG_PAN_POS, 18'h08000); end
        1: begin write_reg(CFG_OUTPUT_RATE, 192000); write_reg(CFG_VOICE_VOL, 65535);
                 write_reg(CFG_PAN_POS, 18'h07fff); end
        2: begin write_reg(CFG_OUTPUT_RATE, 262143); write_reg(CFG_VOICE_VOL, 32768);
                 write_reg(CFG_PAN_POS, 0); end
        default: begin
          write_reg(CFG_OUTPUT_RATE, $urandom_range(1000, 192000));
          write_reg(CFG_VOICE_VOL, $urandom_range(65535));
          write_reg(CFG_PAN_POS, $urandom);
        end
      endcase
      write_reg(2'd3, $urandom);
      for (int i = 0; i < 144; i++) send_item(rand_item());
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
